// ----- rtl/core/scfr_pkg.sv -----
`default_nettype none
package scfr_pkg;

  localparam int VOL_W          = 16;
  localparam int GAIN_FRAC_BITS = 15;
  localparam logic [VOL_W-1:0] GAIN_ONE = VOL_W'(1 << GAIN_FRAC_BITS);

  localparam int DUR_W  = 16;
  localparam int STEP_W = 10;
  localparam int ELA_W  = 17;
  localparam int PROG_W = 16;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_IN     = 3'd1;
  localparam logic [2:0] FUNC_OUT    = 3'd2;
  localparam logic [2:0] FUNC_XF     = 3'd3;
  localparam logic [2:0] FUNC_CANCEL = 3'd4;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_IN   = 2'd1;
  localparam logic [1:0] MODE_OUT  = 2'd2;
  localparam logic [1:0] MODE_XF   = 2'd3;

  localparam logic [1:0] CFG_DURATION = 2'd0;
  localparam logic [1:0] CFG_STEP     = 2'd1;
  localparam logic [1:0] CFG_TARGET   = 2'd2;

  typedef struct packed {
    logic             from_write;
    logic [VOL_W-1:0] from_volume;
    logic             to_write;
    logic [VOL_W-1:0] to_volume;
    logic             stop_from;
    logic             fade_out_done;
    logic             fade_finished;
    logic             last;
  } res_t;

  function automatic logic [VOL_W-1:0] clamp_gain(input logic [VOL_W-1:0] v);
    clamp_gain = (v > GAIN_ONE) ? GAIN_ONE : v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/scfr_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle. Needs num < den.
module scfr_div import scfr_pkg::*; #(
  parameter int Q_W = 16,
  parameter int D_W = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [D_W:0]   num,
  input  wire logic [D_W-1:0] den,
  output logic                done,
  output logic [Q_W-1:0]      quo
);

  localparam int CW = $clog2(Q_W + 1);

  logic [D_W:0]   rem_r;
  logic [D_W-1:0] den_r;
  logic [Q_W-1:0] quo_r;
  logic [CW-1:0]  cnt_r;
  logic           run_r;
  logic           done_r;

  logic [D_W:0] trial;
  logic         fits;

  assign trial = {rem_r[D_W-1:0], 1'b0};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(Q_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
      quo_r <= {quo_r[Q_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ----- rtl/core/scfr_smul.sv -----
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle, product in {hi, lo}.
module scfr_smul import scfr_pkg::*; #(
  parameter int A_W = 32,
  parameter int B_W = 18
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  output logic                  done,
  output logic [A_W+B_W-1:0]    prod
);

  localparam int CW = $clog2(B_W + 1);

  logic [A_W-1:0] a_r;
  logic [A_W-1:0] hi_r;
  logic [B_W-1:0] lo_r;
  logic [CW-1:0]  cnt_r;
  logic           run_r;
  logic           done_r;

  logic [A_W:0] sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : {(A_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(B_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (run_r) begin
      hi_r <= sum[A_W:1];
      lo_r <= {sum[0], lo_r[B_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule
`default_nettype wire

// ----- rtl/core/scfr_rq.sv -----
`default_nettype none
// Two-entry result queue in front of the output channel.
module scfr_rq import scfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  res_t      push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  res_t       ent_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic       pop;
  logic       do_push;

  assign full      = cnt_r == 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = ent_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (pop)     rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ----- rtl/core/smoothstep_crossfade_ramp_core.sv -----
`default_nettype none
// Sequence: a start or cancel request goes from idle to a push for each result it
// makes; a tick that completes a fade goes through check and push, a mid-fade tick
// through check, a 16-bit serial divide, then three 18-bit serial multiplies on one
// shared unit, then build and push.
// Flow: one request at a time; the next is taken once the last result is queued,
// and a full result queue holds the sequencer in push until it has room.
// Reset: synchronous active-low rst_n; mode idle, elapsed and start volume zero,
// registers back to duration 2000 ms, step 20 ms, target unity.
module smoothstep_crossfade_ramp_core import scfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // [15:0] current_volume, [16] channels_present, zero pad
  input  wire logic [2:0]  in_tuser,  // [2:0] func
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata, // [0] from_write, [16:1] from_volume, [17] to_write,
                                      // [33:18] to_volume, [34] stop_from,
                                      // [35] fade_out_done, [36] fade_finished, zero pad
  output logic             out_tlast,
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;  // elapsed vs duration
  localparam logic [2:0] S_DIV  = 3'd2;  // progress divide
  localparam logic [2:0] S_MUL  = 3'd3;  // smoothstep and gain
  localparam logic [2:0] S_RES  = 3'd4;  // build mid-fade result
  localparam logic [2:0] S_PUSH = 3'd5;  // hand results to queue

  // multiplier phases
  localparam logic [1:0] MPH_SQ   = 2'd0;  // p*p
  localparam logic [1:0] MPH_CUBE = 2'd1;  // p^2 * (3 - 2p)
  localparam logic [1:0] MPH_GAIN = 2'd2;  // start_volume * s

  localparam logic [17:0] THREE_Q16 = 18'd196608;
  localparam logic [ELA_W-1:0] ELA_MAX = '1;

  // configuration registers
  logic [DUR_W-1:0]  dur_r;
  logic [STEP_W-1:0] step_r;
  logic [VOL_W-1:0]  tgt_r;

  // ramp state
  logic [1:0]       mode_r;
  logic [ELA_W-1:0] ela_r;
  logic [VOL_W-1:0] sv_r;

  logic [2:0]        st_r;
  logic [1:0]        mph_r;
  logic              mul_go_r;
  logic              div_go_r;
  logic [PROG_W-1:0] p_r;
  logic [31:0]       p2_r;
  logic [16:0]       s_r;
  logic [VOL_W-1:0]  gin_r;
  logic              frac_r;

  res_t       res0_r;
  res_t       res1_r;
  logic [1:0] nres_r;

  // request fields
  logic [2:0]       rq_func;
  logic [VOL_W-1:0] rq_cur;
  logic             rq_present;
  logic             in_hs;

  assign rq_func    = in_tuser;
  assign rq_cur     = clamp_gain(in_tdata[15:0]);
  assign rq_present = in_tdata[16];
  // nothing is taken while reset is held
  assign in_tready  = rst_n && (st_r == S_IDLE);
  assign in_hs      = in_tvalid && in_tready;
  assign cfg_ready  = rst_n;

  // serial units
  logic              div_done;
  logic [PROG_W-1:0] div_q;
  logic              mul_done;
  logic [49:0]       mul_prod;
  logic [31:0]       mul_a;
  logic [17:0]       mul_b;

  scfr_div #(.Q_W(PROG_W), .D_W(DUR_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (ela_r),
    .den   (dur_r),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    case (mph_r)
      MPH_SQ: begin
        mul_a = {16'd0, p_r};
        mul_b = {2'd0, p_r};
      end
      MPH_CUBE: begin
        mul_a = p2_r;
        mul_b = THREE_Q16 - {1'b0, p_r, 1'b0};
      end
      MPH_GAIN: begin
        mul_a = {15'd0, s_r};
        mul_b = {2'd0, sv_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  scfr_smul #(.A_W(32), .B_W(18)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // result queue
  logic q_full;
  res_t q_out;

  scfr_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (st_r == S_PUSH),
    .push_data (res0_r),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_out)
  );

  assign out_tdata = {3'd0, q_out.fade_finished, q_out.fade_out_done, q_out.stop_from,
                      q_out.to_volume, q_out.to_write, q_out.from_volume, q_out.from_write};
  assign out_tlast = q_out.last;

  // helpers
  logic [ELA_W:0]   ela_sum;
  logic             done_now;
  logic [VOL_W-1:0] gout;

  assign ela_sum  = {1'b0, ela_r} + {{(ELA_W+1-STEP_W){1'b0}}, step_r};
  assign done_now = ela_r >= {1'b0, dur_r};
  // floor(sv*(1-s)) = sv - ceil(sv*s)
  assign gout     = sv_r - gin_r - {{(VOL_W-1){1'b0}}, frac_r};

  function automatic res_t mk(input logic fw, input logic [VOL_W-1:0] fv,
                              input logic tw, input logic [VOL_W-1:0] tv,
                              input logic stp, input logic fod, input logic fin,
                              input logic lst);
    res_t r;
    r.from_write    = fw;
    r.from_volume   = fw ? fv : '0;
    r.to_write      = tw;
    r.to_volume     = tw ? tv : '0;
    r.stop_from     = stp;
    r.fade_out_done = fod;
    r.fade_finished = fin;
    r.last          = lst;
    mk = r;
  endfunction

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r  <= DUR_W'(2000);
      step_r <= STEP_W'(20);
      tgt_r  <= GAIN_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DURATION: dur_r  <= cfg_data;
        CFG_STEP:     step_r <= cfg_data[STEP_W-1:0];
        CFG_TARGET:   tgt_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      mode_r   <= MODE_IDLE;
      ela_r    <= '0;
      sv_r     <= '0;
      mph_r    <= MPH_SQ;
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      nres_r   <= 2'd0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_hs) begin
            if (rq_func == FUNC_TICK) begin
              if (mode_r != MODE_IDLE) begin
                ela_r <= ela_sum[ELA_W] ? ELA_MAX : ela_sum[ELA_W-1:0];
                st_r  <= S_CHK;
              end
            end else if (rq_func == FUNC_IN || rq_func == FUNC_OUT ||
                         rq_func == FUNC_XF || rq_func == FUNC_CANCEL) begin
              // every command cancels the running fade
              mode_r <= MODE_IDLE;
              if (rq_func != FUNC_CANCEL && rq_present) begin
                case (rq_func)
                  FUNC_IN: begin
                    if (dur_r == '0) begin
                      res0_r <= mk(1'b0, '0, 1'b1, clamp_gain(tgt_r), 1'b0, 1'b0, 1'b0, 1'b1);
                    end else begin
                      sv_r   <= clamp_gain(tgt_r);
                      ela_r  <= '0;
                      mode_r <= MODE_IN;
                      res0_r <= mk(1'b0, '0, 1'b1, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                    end
                    nres_r <= 2'd1;
                    st_r   <= S_PUSH;
                  end
                  FUNC_OUT: begin
                    if (dur_r == '0) begin
                      res0_r <= mk(1'b1, '0, 1'b0, '0, 1'b0, 1'b1, 1'b1, 1'b1);
                      nres_r <= 2'd1;
                      st_r   <= S_PUSH;
                    end else begin
                      sv_r   <= rq_cur;
                      ela_r  <= '0;
                      mode_r <= MODE_OUT;
                    end
                  end
                  default: begin
                    // crossfade
                    sv_r  <= rq_cur;
                    ela_r <= '0;
                    if (dur_r == '0) begin
                      // direct cut: stop at zero, then restore
                      res0_r <= mk(1'b1, '0, 1'b0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
                      res1_r <= mk(1'b1, rq_cur, 1'b1, rq_cur, 1'b0, 1'b0, 1'b1, 1'b1);
                      nres_r <= 2'd2;
                    end else begin
                      mode_r <= MODE_XF;
                      res0_r <= mk(1'b0, '0, 1'b1, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                      nres_r <= 2'd1;
                    end
                    st_r <= S_PUSH;
                  end
                endcase
              end
            end
          end
        end

        S_CHK: begin
          if (done_now) begin
            mode_r <= MODE_IDLE;
            st_r   <= S_PUSH;
            case (mode_r)
              MODE_IN: begin
                res0_r <= mk(1'b0, '0, 1'b1, sv_r, 1'b0, 1'b0, 1'b1, 1'b1);
                nres_r <= 2'd1;
              end
              MODE_OUT: begin
                res0_r <= mk(1'b1, '0, 1'b0, '0, 1'b0, 1'b1, 1'b1, 1'b1);
                nres_r <= 2'd1;
              end
              default: begin
                res0_r <= mk(1'b1, '0, 1'b1, sv_r, 1'b1, 1'b0, 1'b0, 1'b0);
                res1_r <= mk(1'b1, sv_r, 1'b0, '0, 1'b0, 1'b0, 1'b1, 1'b1);
                nres_r <= 2'd2;
              end
            endcase
          end else begin
            div_go_r <= 1'b1;
            st_r     <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            p_r      <= div_q;
            mph_r    <= MPH_SQ;
            mul_go_r <= 1'b1;
            st_r     <= S_MUL;
          end
        end

        S_MUL: begin
          if (mul_done) begin
            case (mph_r)
              MPH_SQ: begin
                p2_r     <= mul_prod[31:0];
                mph_r    <= MPH_CUBE;
                mul_go_r <= 1'b1;
              end
              MPH_CUBE: begin
                s_r      <= mul_prod[48:32];
                mph_r    <= MPH_GAIN;
                mul_go_r <= 1'b1;
              end
              default: begin
                gin_r  <= mul_prod[31:16];
                frac_r <= |mul_prod[15:0];
                st_r   <= S_RES;
              end
            endcase
          end
        end

        S_RES: begin
          case (mode_r)
            MODE_IN:  res0_r <= mk(1'b0, '0, 1'b1, gin_r, 1'b0, 1'b0, 1'b0, 1'b1);
            MODE_OUT: res0_r <= mk(1'b1, gout, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
            default:  res0_r <= mk(1'b1, gout, 1'b1, gin_r, 1'b0, 1'b0, 1'b0, 1'b1);
          endcase
          nres_r <= 2'd1;
          st_r   <= S_PUSH;
        end

        S_PUSH: begin
          if (!q_full) begin
            if (nres_r == 2'd2) begin
              res0_r <= res1_r;
              nres_r <= 2'd1;
            end else begin
              nres_r <= 2'd0;
              st_r   <= S_IDLE;
            end
          end
        end

        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_smoothstep_crossfade_ramp_core.sv -----
`timescale 1ns / 100ps

import scfr_pkg::*;

// Tracks the fade sequencer's mode, elapsed time and latched gain, and
// queues the gain writes each accepted request should produce.
class fade_gain_board;
  logic [DUR_W-1:0]  duration_ms;
  logic [STEP_W-1:0] step_ms;
  logic [VOL_W-1:0]  target_vol;
  logic [1:0]        mode;
  logic [ELA_W-1:0]  elapsed_ms;
  logic [VOL_W-1:0]  start_vol;
  res_t              expected_gains[$];
  int                failures;

  function new();
    duration_ms = 16'd2000;
    step_ms     = 10'd20;
    target_vol  = GAIN_ONE;
    mode        = MODE_IDLE;
    elapsed_ms  = '0;
    start_vol   = '0;
    failures    = 0;
  endfunction

  function void set_register(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_DURATION: duration_ms = val;
      CFG_STEP:     step_ms = val[STEP_W-1:0];
      CFG_TARGET:   target_vol = val;
      default: ;
    endcase
  endfunction

  function logic [VOL_W-1:0] to_unity(logic [VOL_W-1:0] v);
    return (v > GAIN_ONE) ? GAIN_ONE : v;
  endfunction

  function void expect_gain(bit fw, logic [VOL_W-1:0] fv, bit tw, logic [VOL_W-1:0] tv,
                            bit stop, bit out_done, bit fin, bit lst);
    res_t r;
    r.from_write    = fw;
    r.from_volume   = fw ? fv : '0;
    r.to_write      = tw;
    r.to_volume     = tw ? tv : '0;
    r.stop_from     = stop;
    r.fade_out_done = out_done;
    r.fade_finished = fin;
    r.last          = lst;
    expected_gains.push_back(r);
  endfunction

  // One tick: advance elapsed time, shape progress by smoothstep, emit gains.
  // Returns 0 when idle (tick ignored).
  function bit advance_ramp();
    bit [63:0] sum, p, s, g_in, g_out;
    bit        done;
    if (mode == MODE_IDLE) return 1'b0;
    sum = 64'(elapsed_ms) + 64'(step_ms);
    elapsed_ms = (sum > 64'h1FFFF) ? 17'h1FFFF : sum[ELA_W-1:0];
    done = (elapsed_ms >= 17'(duration_ms));
    if (duration_ms == '0 || done) begin
      p = 64'd65536;
    end else begin
      p = (64'(elapsed_ms) << 16) / 64'(duration_ms);
      if (p > 64'd65536) p = 64'd65536;
    end
    s     = (p * p * (64'd196608 - 64'd2 * p)) >> 32;
    g_in  = (64'(start_vol) * s) >> 16;
    g_out = (64'(start_vol) * (64'd65536 - s)) >> 16;
    case (mode)
      MODE_IN: begin
        if (done) begin
          mode = MODE_IDLE;
          expect_gain(0, '0, 1, start_vol, 0, 0, 1, 1);
        end else begin
          expect_gain(0, '0, 1, g_in[VOL_W-1:0], 0, 0, 0, 1);
        end
      end
      MODE_OUT: begin
        if (done) begin
          mode = MODE_IDLE;
          expect_gain(1, '0, 0, '0, 0, 1, 1, 1);
        end else begin
          expect_gain(1, g_out[VOL_W-1:0], 0, '0, 0, 0, 0, 1);
        end
      end
      MODE_XF: begin
        if (done) begin
          // silence and stop the outgoing side, then restore its gain
          mode = MODE_IDLE;
          expect_gain(1, '0, 1, start_vol, 1, 0, 0, 0);
          expect_gain(1, start_vol, 0, '0, 0, 0, 1, 1);
        end else begin
          expect_gain(1, g_out[VOL_W-1:0], 1, g_in[VOL_W-1:0], 0, 0, 0, 1);
        end
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // Returns 0 for requests the block ignores outright.
  function bit note_request(logic [2:0] func, logic [VOL_W-1:0] vol, logic present);
    logic [VOL_W-1:0] cur;
    cur = to_unity(vol);
    if (func == FUNC_TICK) return advance_ramp();
    if (func > FUNC_CANCEL) return 1'b0;
    mode = MODE_IDLE;
    if (func == FUNC_CANCEL || !present) return 1'b1;
    case (func)
      FUNC_IN: begin
        if (duration_ms == '0) begin
          expect_gain(0, '0, 1, to_unity(target_vol), 0, 0, 0, 1);
        end else begin
          start_vol  = to_unity(target_vol);
          elapsed_ms = '0;
          mode       = MODE_IN;
          expect_gain(0, '0, 1, '0, 0, 0, 0, 1);
        end
      end
      FUNC_OUT: begin
        if (duration_ms == '0) begin
          expect_gain(1, '0, 0, '0, 0, 1, 1, 1);
        end else begin
          start_vol  = cur;
          elapsed_ms = '0;
          mode       = MODE_OUT;
        end
      end
      default: begin
        start_vol  = cur;
        elapsed_ms = '0;
        if (duration_ms == '0) begin
          expect_gain(1, '0, 0, '0, 1, 0, 0, 0);
          expect_gain(1, cur, 1, cur, 0, 0, 1, 1);
        end else begin
          mode = MODE_XF;
          expect_gain(0, '0, 1, '0, 0, 0, 0, 1);
        end
      end
    endcase
    return 1'b1;
  endfunction

  function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      failures++;
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (expected_gains.size() == 0) begin
      $error("unexpected result %h", got);
      failures++;
      return;
    end
    want = expected_gains.pop_front();
    compare_field("from_write", 16'(want.from_write), 16'(got.from_write));
    compare_field("from_volume", want.from_volume, got.from_volume);
    compare_field("to_write", 16'(want.to_write), 16'(got.to_write));
    compare_field("to_volume", want.to_volume, got.to_volume);
    compare_field("stop_from", 16'(want.stop_from), 16'(got.stop_from));
    compare_field("fade_out_done", 16'(want.fade_out_done), 16'(got.fade_out_done));
    compare_field("fade_finished", 16'(want.fade_finished), 16'(got.fade_finished));
    compare_field("last", 16'(want.last), 16'(got.last));
  endfunction

  function int pending();
    return expected_gains.size();
  endfunction
endclass

module tb_smoothstep_crossfade_ramp_core;

  // cycles to let pass once no expected result is pending; a mid-fade tick runs
  // a serial divide and three multiplies, and some requests produce no result at all
  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SEG_REQUESTS  = 160;

  // func codes 5..7 are unassigned and must be ignored by the block
  localparam logic [2:0] FUNC_SPARE_A = FUNC_CANCEL + 3'd1;
  localparam logic [2:0] FUNC_SPARE_B = FUNC_CANCEL + 3'd2;
  localparam logic [2:0] FUNC_SPARE_C = FUNC_CANCEL + 3'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [15:0] current_volume, [16] channels_present, zero pad
  logic [2:0]  in_tuser;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [0] from_write, [16:1] from_volume, [17] to_write,
                           // [33:18] to_volume, [34] stop_from, [35] fade_out_done,
                           // [36] fade_finished, zero pad
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  fade_gain_board sb;
  int             n_items;        // requests accepted so far
  int             send_idle_pct;  // chance per cycle the sender holds off
  int             recv_stall_pct; // chance per cycle the receiver stalls

  smoothstep_crossfade_ramp_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor: sampled on the rising edge, pre-update values
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[0], out_tdata[16:1], out_tdata[17], out_tdata[33:18],
             out_tdata[34], out_tdata[35], out_tdata[36], out_tlast};
      sb.check_result(got);
    end
  end

  // Present one request. Valid is left high after the handshake so the next
  // request can follow back to back; it is only lowered for a gap.
  task automatic send_request(input logic [2:0] func, input logic [15:0] vol,
                              input logic present);
    bit lowered;
    lowered = 1'b0;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) begin
        in_tvalid <= 1'b0;
        lowered = 1'b1;
      end
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {7'd0, present, vol};
    do @(posedge clk); while (!in_tready);
    void'(sb.note_request(func, vol, present));
    n_items++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
  endtask

  task automatic write_regs(input logic [15:0] dur, input logic [15:0] step,
                            input logic [15:0] tgt);
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_STEP, step);
    write_reg(CFG_TARGET, tgt);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every expected result, then let a trailing
  // request with no result finish before anything else happens.
  task automatic drain_results();
    int guard;
    guard = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] any_volume();
    case ($urandom_range(9))
      0:       return '0;
      1:       return GAIN_ONE;
      2:       return 16'($urandom);  // above unity too, block must clamp
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  // Mostly well-formed fades: a start request followed by a run of ticks of random
  // length, at most two past the count that ends the ramp (that count capped at 70),
  // with the odd cancel. The rest is noise: spare codes, stray ticks, aborted starts.
  task automatic run_random(input int goal);
    int         first, span, ticks, k;
    logic [2:0] func;
    first = n_items;
    while (n_items - first < goal) begin
      if ($urandom_range(99) < 10) begin
        send_request(3'($urandom_range(7)), any_volume(), 1'($urandom_range(1)));
      end else begin
        send_request(3'($urandom_range(FUNC_IN, FUNC_XF)), any_volume(),
                     ($urandom_range(15) != 0));
        span = (sb.duration_ms == '0) ? 1 :
               (sb.duration_ms + sb.step_ms - 1) / sb.step_ms;
        if (span > 70) span = 70;
        ticks = $urandom_range(span + 2);
        for (k = 0; k < ticks; k++) begin
          func = ($urandom_range(39) == 0) ? FUNC_CANCEL : FUNC_TICK;
          send_request(func, any_volume(), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  // register settings per random segment: {duration, step, target}
  logic [15:0] seg_dur  [8] = '{16'd100, 16'd0, 16'd65535, 16'd1,
                                16'd997, 16'd0, 16'd300, 16'd5000};
  logic [15:0] seg_step [8] = '{16'd20, 16'd1, 16'd1000, 16'd1,
                                16'd113, 16'd1000, 16'd7, 16'd250};
  logic [15:0] seg_tgt  [8] = '{16'd32768, 16'd0, 16'd16384, 16'd32768,
                                16'd12345, 16'd32768, 16'd1, 16'd32768};

  initial begin
    int seg;
    sb             = new();
    n_items        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = FUNC_TICK;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_DURATION;
    cfg_data       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: a 2-tick ramp so every completion path is short ---
    write_regs(16'd100, 16'd50, GAIN_ONE);
    send_request(FUNC_TICK, 16'hFFFF, 1'b1);     // tick while idle
    send_request(FUNC_SPARE_A, 16'hFFFF, 1'b1);  // unassigned codes
    send_request(FUNC_SPARE_B, 16'h0000, 1'b0);
    send_request(FUNC_SPARE_C, 16'h5A5A, 1'b1);
    send_request(FUNC_IN, 16'h0000, 1'b0);       // missing channel aborts
    send_request(FUNC_IN, 16'h0000, 1'b1);
    send_request(FUNC_TICK, 16'h0000, 1'b0);
    send_request(FUNC_TICK, 16'h0000, 1'b0);     // fade-in completes
    send_request(FUNC_OUT, 16'hFFFF, 1'b1);      // clamped to unity, silent start
    send_request(FUNC_TICK, 16'h0000, 1'b0);
    send_request(FUNC_CANCEL, 16'h0000, 1'b1);
    send_request(FUNC_TICK, 16'h0000, 1'b0);     // idle again
    send_request(FUNC_XF, 16'd20000, 1'b1);
    send_request(FUNC_TICK, 16'h0000, 1'b0);
    send_request(FUNC_TICK, 16'h0000, 1'b0);     // crossfade completion
    send_request(FUNC_OUT, GAIN_ONE, 1'b1);
    send_request(FUNC_TICK, 16'h0000, 1'b0);
    send_request(FUNC_TICK, 16'h0000, 1'b0);     // fade-out done
    send_request(FUNC_XF, 16'h8001, 1'b1);       // left running
    drain_results();

    // duration dropped to zero mid-fade, then the immediate paths
    write_regs(16'd0, 16'd1000, 16'd0);
    send_request(FUNC_TICK, 16'h0000, 1'b1);     // finishes the crossfade
    send_request(FUNC_IN, 16'h0000, 1'b1);
    send_request(FUNC_OUT, 16'd777, 1'b1);
    send_request(FUNC_XF, 16'd12345, 1'b1);      // direct cut
    send_request(FUNC_XF, 16'h0000, 1'b0);
    drain_results();

    // --- random: two register settings per idling scheme ---
    for (seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      write_regs(seg_dur[seg], seg_step[seg], seg_tgt[seg]);
      run_random(SEG_REQUESTS);
      drain_results();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/scfr_pkg.sv
rtl/core/scfr_div.sv
rtl/core/scfr_smul.sv
rtl/core/scfr_rq.sv
rtl/core/smoothstep_crossfade_ramp_core.sv
tb/tb_smoothstep_crossfade_ramp_core.sv
